FILE: hw/rtl/fajd_pkg.sv
// Package: shared types, constants and register indexes of the feeder advance block
`timescale 1ns / 1ps

package fajd_pkg;

    // Field widths
    localparam int LEVER_W  = 11;
    localparam int ENC_W    = 13;
    localparam int SPEED_W  = 16;
    localparam int ANGLE_W  = 32;
    localparam int SHOT_W   = 16;
    localparam int TURN_W   = 24;
    localparam int ARM_W    = 6;
    localparam int TICK_W   = 7;
    localparam int STEP_W   = 18;
    localparam int LAG_W    = 20;
    localparam int STALL_W  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Default encoder resolution
    localparam int COUNTS_PER_TURN_DEF = 8192;

    // Lever codes and arm counter values
    localparam logic [LEVER_W-1:0] PRELOAD_LOW  = 11'd450;
    localparam logic [LEVER_W-1:0] PRELOAD_HIGH = 11'd650;
    localparam logic [LEVER_W-1:0] FIRE_LEVER   = 11'd660;
    localparam logic [ARM_W-1:0]   ARM_PRELOAD  = 6'd38;
    localparam logic [ARM_W-1:0]   ARM_FIRE     = 6'd40;

    // Stall watch timing
    localparam logic [TICK_W-1:0] WATCH_TICKS = 7'd80;
    localparam logic [TICK_W-1:0] JAM_TICKS   = 7'd79;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_SPEED   = 2'd2;

    // Configuration register reset values
    localparam logic [STEP_W-1:0]  STEP_ANGLE_RST    = 18'd36864;
    localparam logic [LAG_W-1:0]   LAG_THRESHOLD_RST = 20'd10000;
    localparam logic [STALL_W-1:0] STALL_SPEED_RST   = 15'd1300;

    typedef struct packed {
        logic [STEP_W-1:0]  step_angle;
        logic [LAG_W-1:0]   lag_threshold;
        logic [STALL_W-1:0] stall_speed;
    } t_cfg;

    typedef struct packed {
        logic jam;
        logic watch;
    } t_shot_status;

endpackage

FILE: hw/rtl/fajd_cfg_regs.sv
// Configuration registers: step angle, lag threshold and stall speed
`timescale 1ns / 1ps

module fajd_cfg_regs
    import fajd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index of a write transfer
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP_ANGLE:    n_cfg.step_angle    = i_cfg_data[STEP_W-1:0];
                CFG_LAG_THRESHOLD: n_cfg.lag_threshold = i_cfg_data[LAG_W-1:0];
                CFG_STALL_SPEED:   n_cfg.stall_speed   = i_cfg_data[STALL_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_angle    <= STEP_ANGLE_RST;
            r_cfg.lag_threshold <= LAG_THRESHOLD_RST;
            r_cfg.stall_speed   <= STALL_SPEED_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/fajd_shot_ctrl.sv
// Shot control: arm counter, target angle, shot count and post-shot stall watch
`timescale 1ns / 1ps

module fajd_shot_ctrl
    import fajd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  t_cfg                       i_cfg,
    input  logic [LEVER_W-1:0]         i_lever,
    input  logic signed [SPEED_W-1:0]  i_speed,
    input  logic signed [ANGLE_W-1:0]  i_total_prev,
    output logic signed [ANGLE_W-1:0]  o_goal_next,
    output logic [SHOT_W-1:0]          o_shots_next,
    output t_shot_status               o_status
);

    logic [ARM_W-1:0]          r_arm, n_arm;
    logic signed [ANGLE_W-1:0] r_goal, n_goal;
    logic [SHOT_W-1:0]         r_shots, n_shots;
    logic                      r_watch, n_watch;
    logic [TICK_W-1:0]         r_stall, n_stall;
    logic [TICK_W-1:0]         r_window, n_window;
    logic signed [SPEED_W-1:0] r_speed;

    logic [ARM_W:0]            arm_inc;
    logic                      fire;
    logic signed [ANGLE_W-1:0] goal_shot;
    logic signed [ANGLE_W+1:0] lag;
    logic                      lagging;
    logic                      slow;
    logic                      jam;

    // Arm counter: preload band, count up on fire lever, fire at the top
    always_comb begin
        n_arm   = r_arm;
        arm_inc = '0;
        if (i_lever inside {[PRELOAD_LOW + 11'd1 : PRELOAD_HIGH - 11'd1]}) begin
            n_arm = ARM_PRELOAD;
        end
        if (i_lever == FIRE_LEVER) begin
            arm_inc = {1'b0, n_arm} + 7'd1;
            if (arm_inc > {1'b0, ARM_FIRE}) begin
                n_arm = ARM_FIRE;
            end else begin
                n_arm = arm_inc[ARM_W-1:0];
            end
        end
        fire = (n_arm == ARM_FIRE);
        if (fire) begin
            n_arm = '0;
        end
    end

    // Advance the goal and the shot count on a shot
    assign goal_shot = fire ? r_goal + $signed({{(ANGLE_W-STEP_W){1'b0}}, i_cfg.step_angle})
                            : r_goal;
    assign n_shots   = fire ? r_shots + 16'd1 : r_shots;

    // Exact lag test: goal minus previous total above the threshold
    assign lag     = {{2{goal_shot[ANGLE_W-1]}}, goal_shot}
                   - {{2{i_total_prev[ANGLE_W-1]}}, i_total_prev};
    assign lagging = lag > $signed({{(ANGLE_W+2-LAG_W){1'b0}}, i_cfg.lag_threshold});
    assign slow    = $signed({r_speed[SPEED_W-1], r_speed})
                   < $signed({2'b00, i_cfg.stall_speed});

    // Stall watch: count ticks and stall ticks, close after the window
    always_comb begin
        n_watch  = r_watch | fire;
        n_stall  = r_stall;
        n_window = r_window;
        jam      = 1'b0;
        if (n_watch) begin
            if (lagging && slow) begin
                n_stall = r_stall + 7'd1;
            end
            n_window = r_window + 7'd1;
            if (n_window >= WATCH_TICKS) begin
                n_window = '0;
                n_stall  = '0;
                n_watch  = 1'b0;
            end
            jam = (n_stall >= JAM_TICKS);
        end
    end

    // Drop the goal to zero on a jam
    assign n_goal = jam ? '0 : goal_shot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm    <= '0;
            r_goal   <= '0;
            r_shots  <= '0;
            r_watch  <= 1'b0;
            r_stall  <= '0;
            r_window <= '0;
            r_speed  <= '0;
        end else if (i_step) begin
            r_arm    <= n_arm;
            r_goal   <= n_goal;
            r_shots  <= n_shots;
            r_watch  <= n_watch;
            r_stall  <= n_stall;
            r_window <= n_window;
            r_speed  <= i_speed;
        end
    end

    assign o_goal_next    = n_goal;
    assign o_shots_next   = n_shots;
    assign o_status.jam   = jam;
    assign o_status.watch = n_watch;

endmodule

FILE: hw/rtl/fajd_unwrap.sv
// Encoder unwrap: turn count and multi-turn total angle from single-turn readings
`timescale 1ns / 1ps

module fajd_unwrap
    import fajd_pkg::*;
#(
    parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [ENC_W-1:0]          i_angle,
    input  logic                      i_jam,
    output logic signed [ANGLE_W-1:0] o_total_prev,
    output logic signed [ANGLE_W-1:0] o_total_next
);

    localparam int DELTA_W = 18;
    localparam logic signed [DELTA_W-1:0] HALF_TURN_TEST =
        DELTA_W'(COUNTS_PER_TURN / 2 - 4);
    localparam logic signed [ANGLE_W-1:0] TURN_COUNTS = ANGLE_W'(COUNTS_PER_TURN);

    logic [TURN_W-1:0]         r_turn, n_turn;
    logic [ENC_W-1:0]          r_prev;
    logic signed [ANGLE_W-1:0] r_total;
    logic signed [DELTA_W-1:0] delta;
    logic signed [ANGLE_W-1:0] turn_ext;
    logic signed [ANGLE_W-1:0] turn_base;
    logic signed [ANGLE_W-1:0] total_calc;

    // Half-turn test against the previous reading
    assign delta = $signed({{(DELTA_W-ENC_W){1'b0}}, i_angle})
                 - $signed({{(DELTA_W-ENC_W){1'b0}}, r_prev});

    always_comb begin
        n_turn = r_turn;
        if (delta < -HALF_TURN_TEST) begin
            n_turn = r_turn + 24'd1;
        end
        if (delta > HALF_TURN_TEST) begin
            n_turn = r_turn - 24'd1;
        end
    end

    // Scale turns to counts and add the single-turn reading
    assign turn_ext   = {{(ANGLE_W-TURN_W){n_turn[TURN_W-1]}}, n_turn};
    assign turn_base  = ANGLE_W'(turn_ext * TURN_COUNTS);
    assign total_calc = turn_base + $signed({{(ANGLE_W-ENC_W){1'b0}}, i_angle});

    assign o_total_next = i_jam ? '0 : total_calc;
    assign o_total_prev = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn  <= '0;
            r_prev  <= '0;
            r_total <= '0;
        end else if (i_step) begin
            r_turn  <= n_turn;
            r_prev  <= i_angle;
            r_total <= o_total_next;
        end
    end

endmodule

FILE: hw/rtl/feeder_advance_and_jam_detect.sv
// Top level: input register, shot and unwrap update, result register
`timescale 1ns / 1ps

// Feeder advance and jam detect. Each transfer on the input channel is one
// control tick (lever, encoder reading, speed) and yields exactly one result
// transfer (target angle, total angle, shot count, jam flag, watch flag).
// The block takes one tick per clock cycle while the output side is ready; a
// tick is registered on entry in the input register, then the shot/stall-watch
// update and the encoder unwrap (one constant multiply and one add) run
// combinationally into the result register, from which the result is driven;
// the new state is registered alongside. Configuration writes are taken in any
// cycle and must only be issued while no tick is in flight.
module feeder_advance_and_jam_detect
    import fajd_pkg::*;
#(
    parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [LEVER_W-1:0]        i_remote_lever,
    input  logic [ENC_W-1:0]          i_encoder_angle,
    input  logic signed [SPEED_W-1:0] i_feeder_speed,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [ANGLE_W-1:0] o_target_angle,
    output logic signed [ANGLE_W-1:0] o_total_angle,
    output logic [SHOT_W-1:0]         o_shot_count,
    output logic                      o_jam_detected,
    output logic                      o_watch_active
);

    t_cfg                      cfg;
    t_shot_status              status;
    logic                      step;
    logic                      in_take;
    logic                      r_in_valid;
    logic [LEVER_W-1:0]        r_lever;
    logic [ENC_W-1:0]          r_angle;
    logic signed [SPEED_W-1:0] r_speed;
    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_target, r_total;
    logic [SHOT_W-1:0]         r_shots;
    logic                      r_jam, r_watch;
    logic signed [ANGLE_W-1:0] goal_next, total_next, total_prev;
    logic [SHOT_W-1:0]         shots_next;

    assign o_cfg_ready = 1'b1;

    fajd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: process the held tick when the result register is free
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_take    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_lever <= i_remote_lever;
            r_angle <= i_encoder_angle;
            r_speed <= i_feeder_speed;
        end
    end

    fajd_shot_ctrl u_shot_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cfg        (cfg),
        .i_lever      (r_lever),
        .i_speed      (r_speed),
        .i_total_prev (total_prev),
        .o_goal_next  (goal_next),
        .o_shots_next (shots_next),
        .o_status     (status)
    );

    fajd_unwrap #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_unwrap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_angle      (r_angle),
        .i_jam        (status.jam),
        .o_total_prev (total_prev),
        .o_total_next (total_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_target <= goal_next;
            r_total  <= total_next;
            r_shots  <= shots_next;
            r_jam    <= status.jam;
            r_watch  <= status.watch;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target_angle = r_target;
    assign o_total_angle  = r_total;
    assign o_shot_count   = r_shots;
    assign o_jam_detected = r_jam;
    assign o_watch_active = r_watch;

`ifndef SYNTHESIS
    // A jam leaves the watch open
    a_jam_in_watch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jam_detected) |-> o_watch_active)
        else $error("jam reported with the stall watch closed");

    // A jam zeroes both angles
    a_jam_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jam_detected) |-> (o_target_angle == 0 && o_total_angle == 0))
        else $error("jam reported with nonzero angles");

    // Input side stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while the result register can drain");
`endif

endmodule
